// File: hw/rtl/rcws_pkg.sv
// ----------------------------------------------------------------------------
// rcws_pkg
// Shared types, constants and helpers for the record control word swapper.
// ----------------------------------------------------------------------------
package rcws_pkg;

  localparam int WORD_BYTES = 4;
  localparam int WORD_W     = 8 * WORD_BYTES;
  localparam int BODY_W     = 23;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BODY_W-1:0] body_cnt_t;

  // Record phase: what the next word of the stream is expected to be.
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_DATA1 = 3'd1,
    PH_DATA2 = 3'd2,
    PH_BODY  = 3'd3,
    PH_TRAIL = 3'd4
  } phase_t;

  // Formatted result of one word.
  typedef struct packed {
    word_t word;
    logic  is_control;
    logic  record_end;
  } rcws_res_t;

  // Sequencer status, visible to the top level for checking.
  typedef struct packed {
    phase_t    phase;
    body_cnt_t body_left;
  } rcws_stat_t;

  function automatic word_t reverse_bytes(input word_t w);
    word_t r;
    r = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      r[8*(WORD_BYTES-1-i) +: 8] = w[8*i +: 8];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/record_control_word_swapper.sv
// ----------------------------------------------------------------------------
// record_control_word_swapper
// Registered path: input register, then result register. Throughput: one
//   word per cycle while the output is not stalled, set by the phase/count
//   update between the two registers.
// Reset (synchronous, rst_n low): both stages empty, phase waits for a
//   leading control word, body count zero.
// ----------------------------------------------------------------------------
module record_control_word_swapper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rcws_pkg::word_t     in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rcws_pkg::word_t     out_word,
  output logic                out_is_control,
  output logic                out_record_end
);
  import rcws_pkg::*;

  // Input stage
  logic       s1_valid_r;
  word_t      s1_word_r;

  // Result stage
  logic       out_valid_r;
  rcws_res_t  out_res_r;

  rcws_res_t  res;
  rcws_stat_t stat;

  logic out_free;   // result register may load this cycle
  logic adv;        // input stage word moves to the result register
  logic in_xfer;    // input transfer

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  // Input stage can take a word when empty or when its word moves on.
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  rcws_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .word  (s1_word_r),
    .res   (res),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_word_r <= in_word;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word       = out_res_r.word;
  assign out_is_control = out_res_r.is_control;
  assign out_record_end = out_res_r.record_end;

  // Record end only ever comes with a swapped control word.
  a_end_is_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_res_r.record_end || out_res_r.is_control))
    else $error("record_end without is_control");

  // The body phase always has words left to pass.
  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.phase == PH_BODY) |-> (stat.body_left != '0))
    else $error("body phase with zero count");

  // A trailing control word returns the tracker to the leading control word.
  a_trail_to_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stat.phase == PH_TRAIL) |=> (stat.phase == PH_LEAD))
    else $error("phase did not return to leading control");

  // A word held at the input stage while the result stalls is kept.
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (s1_valid_r && $stable(s1_word_r)))
    else $error("input stage lost a word under stall");

endmodule

// File: hw/rtl/rcws_seq.sv
// ----------------------------------------------------------------------------
// rcws_seq
// Record phase tracker and word formatter. Holds phase and body count,
// advances them on each word that moves into the result register.
// ----------------------------------------------------------------------------
module rcws_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  rcws_pkg::word_t    word,
  output rcws_pkg::rcws_res_t res,
  output rcws_pkg::rcws_stat_t stat
);
  import rcws_pkg::*;

  phase_t    phase_r,     phase_nxt;
  body_cnt_t body_left_r, body_left_nxt;
  body_cnt_t body_dec;

  assign body_dec = body_left_r - body_cnt_t'(1);

  // Next state
  always_comb begin
    phase_nxt     = phase_r;
    body_left_nxt = body_left_r;
    unique case (phase_r)
      PH_DATA1: phase_nxt = PH_DATA2;
      PH_DATA2: begin
        // Body length is 2*floor(L/8), L = word[31:8].
        body_left_nxt = {1'b0, word[WORD_W-1:11], 1'b0};
        phase_nxt     = (word[WORD_W-1:11] != '0) ? PH_BODY : PH_TRAIL;
      end
      PH_BODY: begin
        body_left_nxt = body_dec;
        if (body_dec == '0) begin
          phase_nxt = PH_TRAIL;
        end
      end
      PH_TRAIL: phase_nxt = PH_LEAD;
      default:  phase_nxt = PH_DATA1;
    endcase
  end

  // Outputs
  always_comb begin
    res.word       = word;
    res.is_control = 1'b0;
    res.record_end = 1'b0;
    unique case (phase_r)
      PH_DATA1, PH_DATA2, PH_BODY: begin
        res.word = word;
      end
      PH_TRAIL: begin
        res.word       = reverse_bytes(word);
        res.is_control = 1'b1;
        res.record_end = 1'b1;
      end
      default: begin
        res.word       = reverse_bytes(word);
        res.is_control = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      body_left_r <= '0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      body_left_r <= body_left_nxt;
    end
  end

  assign stat.phase     = phase_r;
  assign stat.body_left = body_left_r;

endmodule

// File: test/record_control_word_swapper_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_control_word_swapper_checker
// Watches both channels of the swapper, tracks the record framing of every
// accepted input word and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module record_control_word_swapper_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  rcws_pkg::word_t in_word,
  input  logic            out_valid,
  input  logic            out_stall,
  input  rcws_pkg::word_t out_word,
  input  logic            out_is_control,
  input  logic            out_record_end,
  output int              fail_count,
  output int              pending
);
  import rcws_pkg::*;

  phase_t     rec_phase;
  body_cnt_t  body_left;
  rcws_res_t  expected_words [$];
  int         errors      = 0;
  int         outstanding = 0;

  assign fail_count = errors;
  assign pending    = outstanding;

  function automatic word_t swap_word_bytes(input word_t w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    rcws_res_t exp_res;
    if (!rst_n) begin
      rec_phase = PH_LEAD;
      body_left = '0;
      expected_words.delete();
      outstanding = 0;
    end else begin
      // results first: nothing accepted at this edge can already be out
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result with nothing expected", out_word, '0);
        end else begin
          exp_res = expected_words.pop_front();
          outstanding = expected_words.size();
          if (out_word !== exp_res.word)
            report_mismatch("out_word", out_word, exp_res.word);
          if (out_is_control !== exp_res.is_control)
            report_mismatch("out_is_control", word_t'(out_is_control),
                            word_t'(exp_res.is_control));
          if (out_record_end !== exp_res.record_end)
            report_mismatch("out_record_end", word_t'(out_record_end),
                            word_t'(exp_res.record_end));
        end
      end

      if (in_valid && !in_stall) begin
        exp_res.word       = in_word;
        exp_res.is_control = 1'b0;
        exp_res.record_end = 1'b0;
        case (rec_phase)
          PH_DATA1: rec_phase = PH_DATA2;
          PH_DATA2: begin
            // 24-bit length in bits 31..8; body is 2 * floor(L / 8) words
            body_left = {1'b0, in_word[31:11], 1'b0};
            rec_phase = (body_left != '0) ? PH_BODY : PH_TRAIL;
          end
          PH_BODY: begin
            body_left = body_left - 1'b1;
            if (body_left == '0)
              rec_phase = PH_TRAIL;
          end
          PH_TRAIL: begin
            exp_res.word       = swap_word_bytes(in_word);
            exp_res.is_control = 1'b1;
            exp_res.record_end = 1'b1;
            rec_phase          = PH_LEAD;
          end
          default: begin
            exp_res.word       = swap_word_bytes(in_word);
            exp_res.is_control = 1'b1;
            rec_phase          = PH_DATA1;
          end
        endcase
        expected_words.push_back(exp_res);
        outstanding = expected_words.size();
      end
    end
  end

endmodule

// File: test/record_control_word_swapper_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_control_word_swapper_test
// Drives record streams into the swapper: a short directed set of records,
// then about a thousand random words, mostly well-formed records with some
// broken records and filler. Both sides idle and stall at random. The
// checker beside the block predicts and compares; this module only makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module record_control_word_swapper_test;
  import rcws_pkg::*;

  // Cycle budget: a hard stop for the run, set to cover all transfers with
  // their random source gaps and sink stalls.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 1000;
  localparam int TAIL_BODY    = 16;

  // Directed records, aligned from reset:
  //   L = 7    -> empty body (length just under one 8-byte unit)
  //   L = 8    -> two body words, all-ones / all-zeros data
  //   L = 0    -> empty body, zero second data word and zero trailer
  //   L = 23   -> four body words, low length bits set
  localparam word_t DIRECTED_WORDS [22] = '{
    32'h0123_4567, 32'hFFFF_FFFF, 32'h0000_07FF, 32'h89AB_CDEF,
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0800, 32'hFFFF_FFFF, 32'h0000_0000,
    32'hFFFF_FFFF,
    32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0000, 32'h0000_0000,
    32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0000_17C3, 32'h1357_9BDF, 32'h2468_ACE0,
    32'hF0F0_0F0F, 32'h0F0F_F0F0, 32'hFEDC_BA98
  };

  logic  clk;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  word_t in_word   = '0;
  logic  out_stall = 1'b0;
  logic  in_stall;
  logic  out_valid;
  word_t out_word;
  logic  out_is_control;
  logic  out_record_end;

  int    fail_count;
  int    pending;
  int    words_sent  = 0;
  int    cycle_count = 0;
  int    stall_run   = 0;
  bit    calm        = 1'b0;   // no idling on either side while set

  record_control_word_swapper u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .out_is_control (out_is_control),
    .out_record_end (out_record_end)
  );

  record_control_word_swapper_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .out_is_control (out_is_control),
    .out_record_end (out_record_end),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Idle lengths: mostly drawn from the short range, one time in ten from the long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Sink side: stall bursts start at random unless in a calm stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_run <= gap_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One input transfer. An optional gap comes first; stall is looked at on
  // the falling edge, so the accepting rising edge is known without a race.
  task automatic send_word(input word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // Small filler words: bits 31..8 are zero, so any filler word that lands
  // in the second data slot gives L = 0 and the block's framing is known.
  task automatic send_filler(input int count);
    repeat (count) send_word({24'h0, 8'($urandom)});
  endtask

  // One record of random content with length len. A nonzero cut stops it
  // after that many words; filler then brings the stream back in frame:
  // before the second data word, filler finishes a zero-length record;
  // after it, filler stands in for the rest of the body and the trailer.
  task automatic send_record(input logic [23:0] len, input int cut);
    int total;
    total = 4 + 2 * int'(len >> 3);
    for (int i = 0; i < total && (cut == 0 || i < cut); i++) begin
      if (i == 2)
        send_word({len, 8'($urandom)});
      else
        send_word($urandom);
    end
    if (cut != 0)
      send_filler((cut < 3) ? 4 - cut : total - cut);
  endtask

  initial begin
    logic [23:0] rec_len;
    int          pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_WORDS[i])
      send_word(DIRECTED_WORDS[i]);

    // Random part: mostly whole records, some cut short, some filler.
    while (words_sent < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0)
        rec_len = 24'($urandom_range(64, 400));
      else
        rec_len = 24'($urandom_range(0, 63));
      if (pick == 0)
        send_filler(4 * $urandom_range(1, 3));
      else if (pick == 1)
        send_record(rec_len, $urandom_range(1, 3 + 2 * int'(rec_len >> 3)));
      else
        send_record(rec_len, 0);
    end

    // Largest length, then the stream just stops inside the body: the
    // counter is loaded with 2^22-2 and only a few body words follow.
    calm = 1'b0;
    send_word($urandom);
    send_word($urandom);
    send_word(32'hFFFF_FFFF);
    repeat (TAIL_BODY) send_word($urandom);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rcws_pkg.sv
hw/rtl/rcws_seq.sv
hw/rtl/record_control_word_swapper.sv
test/record_control_word_swapper_checker.sv
test/record_control_word_swapper_test.sv
